// ----- src/rlc_pkg.sv -----
// shared constants, types and codes for the route lru cache
package rlc_pkg;

   // cache geometry
   localparam int ENTRIES = 64;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   // field widths
   localparam int KEY_W       = 64;
   localparam int STAMP_W     = 32;
   localparam int DATA_W      = 208;
   localparam int REQ_TDATA_W = KEY_W + DATA_W;
   localparam int RSP_TDATA_W = DATA_W;
   localparam int STATUS_W    = 3;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [STAMP_W-1:0] stamp_type;
   typedef logic [DATA_W-1:0]  data_type;

   // request operation codes carried on req_tuser
   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_ADD    = 1'b1
   } op_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_MISS    = 3'd0,
      STATUS_HIT     = 3'd1,
      STATUS_REFRESH = 3'd2,
      STATUS_APPEND  = 3'd3,
      STATUS_EVICT   = 3'd4
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_FINISH
   } state_type;

endpackage

// ----- src/rlc_ram.sv -----
// simple dual-port synchronous ram with registered read data
module rlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/route_lru_cache.sv -----
// top level of the route lru cache: sequencer, scan and result register
//
// Fully associative cache of route codes keyed by a packed callsign.
// Request channel (req_): req_tuser is the operation, 0 lookup and 1 add or
// refresh; req_tdata carries the key and the route codes. Response channel
// (rsp_): rsp_tuser is the status (miss, hit, refreshed, appended, evicted),
// rsp_tdata the stored codes on a lookup hit and zero otherwise. Every
// request gives exactly one response.
// Each transaction issues one key and stamp read per filled entry, then
// finishes the last compare and closes the scan, does the write-back in
// S_DECIDE and loads the response register in S_FINISH. The next request
// can be taken in the same cycle as the response shows.
// The response register decouples the two sides: a new request is taken
// while an earlier response still waits; if the receiver stalls, the next
// transaction holds in S_FINISH until the register frees.
// Reset empties the cache and clears the use counter at once; no clearing
// pass is needed, entries above the fill count are never read.
module route_lru_cache (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // op
   input  logic                             req_tuser,
   // callsign key, airline icao code, airline iata code, flight number,
   // departure iata, departure icao, arrival iata, arrival icao
   input  logic [rlc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status
   output logic [rlc_pkg::STATUS_W-1:0]     rsp_tuser,
   // stored airline icao, airline iata, flight number, departure iata,
   // departure icao, arrival iata, arrival icao
   output logic [rlc_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   rlc_pkg::state_type  state_ff, state_in;

   // latched request
   logic                req_op_ff, req_op_in;
   rlc_pkg::key_type    req_key_ff, req_key_in;
   rlc_pkg::data_type   req_data_ff, req_data_in;

   // cache bookkeeping
   rlc_pkg::cnt_type    entry_count_ff, entry_count_in;
   rlc_pkg::stamp_type  use_tick_ff, use_tick_in;

   // scan pipeline
   rlc_pkg::cnt_type    issue_cnt_ff, issue_cnt_in;
   logic                cmp_valid_ff, cmp_valid_in;
   rlc_pkg::idx_type    cmp_idx_ff, cmp_idx_in;
   logic                found_ff, found_in;
   rlc_pkg::idx_type    hit_idx_ff, hit_idx_in;
   rlc_pkg::stamp_type  oldest_stamp_ff, oldest_stamp_in;
   rlc_pkg::idx_type    old_idx_ff, old_idx_in;
   rlc_pkg::status_type status_ff, status_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   rlc_pkg::status_type rsp_status_ff, rsp_status_in;
   rlc_pkg::data_type   rsp_data_ff, rsp_data_in;

   // memory ports
   logic                scan_rd_en;
   logic                data_rd_en;
   logic                entry_wr_en;
   logic                stamp_wr_en;
   rlc_pkg::idx_type    wr_idx;
   rlc_pkg::key_type    key_rd;
   rlc_pkg::stamp_type  stamp_rd;
   rlc_pkg::data_type   data_rd;

   logic                req_fire;
   logic                scan_done;
   logic                rsp_load;

   assign req_tready = (state_ff == rlc_pkg::S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign scan_done  = (issue_cnt_ff == entry_count_ff) && !cmp_valid_ff;
   assign rsp_load   = (state_ff == rlc_pkg::S_FINISH) && (!rsp_valid_ff || rsp_tready);

   // key store, read by the scan
   rlc_ram #(.WIDTH(rlc_pkg::KEY_W), .DEPTH(rlc_pkg::ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (entry_wr_en),
      .wr_addr (wr_idx),
      .wr_data (req_key_ff),
      .rd_en   (scan_rd_en),
      .rd_addr (issue_cnt_ff[rlc_pkg::IDX_W-1:0]),
      .rd_data (key_rd)
   );

   // use stamps, read alongside the keys
   rlc_ram #(.WIDTH(rlc_pkg::STAMP_W), .DEPTH(rlc_pkg::ENTRIES)) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_wr_en),
      .wr_addr (wr_idx),
      .wr_data (use_tick_ff),
      .rd_en   (scan_rd_en),
      .rd_addr (issue_cnt_ff[rlc_pkg::IDX_W-1:0]),
      .rd_data (stamp_rd)
   );

   // route codes, laid out as the response payload
   rlc_ram #(.WIDTH(rlc_pkg::DATA_W), .DEPTH(rlc_pkg::ENTRIES)) u_data_ram (
      .clock   (clock),
      .wr_en   (entry_wr_en),
      .wr_addr (wr_idx),
      .wr_data (req_data_ff),
      .rd_en   (data_rd_en),
      .rd_addr (hit_idx_ff),
      .rd_data (data_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rlc_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = rlc_pkg::S_SCAN;
            end
         end
         rlc_pkg::S_SCAN: begin
            if (scan_done) begin
               state_in = rlc_pkg::S_DECIDE;
            end
         end
         rlc_pkg::S_DECIDE: begin
            state_in = rlc_pkg::S_FINISH;
         end
         rlc_pkg::S_FINISH: begin
            if (rsp_load) begin
               state_in = rlc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rlc_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and memory controls
   always_comb begin
      req_op_in       = req_op_ff;
      req_key_in      = req_key_ff;
      req_data_in     = req_data_ff;
      entry_count_in  = entry_count_ff;
      use_tick_in     = use_tick_ff;
      issue_cnt_in    = issue_cnt_ff;
      cmp_valid_in    = 1'b0;
      cmp_idx_in      = issue_cnt_ff[rlc_pkg::IDX_W-1:0];
      found_in        = found_ff;
      hit_idx_in      = hit_idx_ff;
      oldest_stamp_in = oldest_stamp_ff;
      old_idx_in      = old_idx_ff;
      status_in       = status_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_data_in     = rsp_data_ff;
      scan_rd_en      = 1'b0;
      data_rd_en      = 1'b0;
      entry_wr_en     = 1'b0;
      stamp_wr_en     = 1'b0;
      wr_idx          = hit_idx_ff;

      // response leaves
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // compare stage of the scan: first key match, smallest stamp
      if (cmp_valid_ff) begin
         if (!found_ff && (key_rd == req_key_ff)) begin
            found_in   = 1'b1;
            hit_idx_in = cmp_idx_ff;
         end
         if ((cmp_idx_ff == '0) || (stamp_rd < oldest_stamp_ff)) begin
            oldest_stamp_in = stamp_rd;
            old_idx_in      = cmp_idx_ff;
         end
      end

      case (state_ff)
         rlc_pkg::S_IDLE: begin
            if (req_fire) begin
               req_op_in    = req_tuser;
               req_key_in   = req_tdata[rlc_pkg::KEY_W-1:0];
               req_data_in  = req_tdata[rlc_pkg::REQ_TDATA_W-1:rlc_pkg::KEY_W];
               issue_cnt_in = '0;
               found_in     = 1'b0;
            end
         end
         rlc_pkg::S_SCAN: begin
            // issue one read of the filled entries per cycle
            if (issue_cnt_ff != entry_count_ff) begin
               scan_rd_en   = 1'b1;
               cmp_valid_in = 1'b1;
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
         end
         rlc_pkg::S_DECIDE: begin
            if (req_op_ff == rlc_pkg::OP_LOOKUP) begin
               // lookup: stamp the hit and fetch its codes
               if (found_ff) begin
                  status_in   = rlc_pkg::STATUS_HIT;
                  data_rd_en  = 1'b1;
                  stamp_wr_en = 1'b1;
                  wr_idx      = hit_idx_ff;
                  use_tick_in = use_tick_ff + 1'b1;
               end else begin
                  status_in = rlc_pkg::STATUS_MISS;
               end
            end else begin
               // add: refresh, append or replace the oldest
               entry_wr_en = 1'b1;
               stamp_wr_en = 1'b1;
               use_tick_in = use_tick_ff + 1'b1;
               if (found_ff) begin
                  status_in = rlc_pkg::STATUS_REFRESH;
                  wr_idx    = hit_idx_ff;
               end else if (entry_count_ff < rlc_pkg::CNT_W'(rlc_pkg::ENTRIES)) begin
                  status_in      = rlc_pkg::STATUS_APPEND;
                  wr_idx         = entry_count_ff[rlc_pkg::IDX_W-1:0];
                  entry_count_in = entry_count_ff + 1'b1;
               end else begin
                  status_in = rlc_pkg::STATUS_EVICT;
                  wr_idx    = old_idx_ff;
               end
            end
         end
         rlc_pkg::S_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = (status_ff == rlc_pkg::STATUS_HIT) ? data_rd : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rlc_pkg::S_IDLE;
         entry_count_ff <= '0;
         use_tick_ff    <= '0;
         issue_cnt_ff   <= '0;
         cmp_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         use_tick_ff    <= use_tick_in;
         issue_cnt_ff   <= issue_cnt_in;
         cmp_valid_ff   <= cmp_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_op_ff       <= req_op_in;
      req_key_ff      <= req_key_in;
      req_data_ff     <= req_data_in;
      cmp_idx_ff      <= cmp_idx_in;
      found_ff        <= found_in;
      hit_idx_ff      <= hit_idx_in;
      oldest_stamp_ff <= oldest_stamp_in;
      old_idx_ff      <= old_idx_in;
      status_ff       <= status_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_data_ff;

   // fill count never passes the cache size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= rlc_pkg::CNT_W'(rlc_pkg::ENTRIES))
      else $error("entry count above cache size");

   // the scan never issues past the filled entries
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      issue_cnt_ff <= entry_count_ff)
      else $error("scan issued beyond fill count");

   // every stamp taken advances the use counter by one
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rlc_pkg::S_DECIDE && (req_op_ff == rlc_pkg::OP_ADD || found_ff))
      |=> use_tick_ff == $past(use_tick_ff) + 1'b1)
      else $error("use counter did not advance");

   // eviction only happens with a full cache
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rlc_pkg::S_FINISH && status_ff == rlc_pkg::STATUS_EVICT)
      |-> entry_count_ff == rlc_pkg::CNT_W'(rlc_pkg::ENTRIES))
      else $error("eviction while cache not full");

   // codes are returned on a hit only
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != rlc_pkg::STATUS_HIT) |-> rsp_data_ff == '0)
      else $error("non-zero payload on a non-hit response");

endmodule
